>>> hw/rtl/utf8_char_decoder_top_defines.svh
// assertion macros for the utf8 character decoder top level
`ifndef UTF8_CHAR_DECODER_TOP_DEFINES_SVH
`define UTF8_CHAR_DECODER_TOP_DEFINES_SVH

// antecedent holds at an edge, consequent holds at the same edge
`define UTF8D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds at an edge, consequent holds at the next edge
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/utf8d_pkg.sv
// shared types and constants for the utf8 character decoder
`default_nettype none

package utf8d_pkg;

  localparam int unsigned NUM_LANES = 4;

  localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
  localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;

  localparam logic [2:0] ADV_NUL     = 3'd0;
  localparam logic [2:0] ADV_INVALID = 3'd1;

  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  advance;
    logic        replaced;
  } out_item_t;

  // what one lane finds in its byte
  typedef struct packed {
    logic       is_cont;
    logic       is_nul;
    logic       lead_bad;
    logic [2:0] lead_len;
    logic [6:0] data;
  } lane_info_t;

endpackage

`default_nettype wire

>>> hw/rtl/utf8d_lane.sv
// per-byte classifier lane of the utf8 character decoder
`default_nettype none

module utf8d_lane (
  input  wire logic [7:0]            byte_in,
  output utf8d_pkg::lane_info_t      info
);
  import utf8d_pkg::*;

  logic [2:0] len;

  always_comb begin
    case (byte_in) inside
      [8'h00:8'h7F]: len = LEN_1;
      [8'hC0:8'hDF]: len = LEN_2;
      [8'hE0:8'hEF]: len = LEN_3;
      [8'hF0:8'hF7]: len = LEN_4;
      default:       len = LEN_BAD;
    endcase
  end

  always_comb begin
    info.is_cont  = (byte_in[7:6] == 2'b10);
    info.is_nul   = (byte_in == 8'h00);
    info.lead_bad = (byte_in == 8'hC0) || (byte_in == 8'hC1) || (byte_in >= 8'hF5);
    info.lead_len = len;
    info.data     = byte_in[6:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/utf8d_merge.sv
// merging stage: combines lane findings into one decoded character
`default_nettype none

module utf8d_merge (
  input  wire utf8d_pkg::lane_info_t [utf8d_pkg::NUM_LANES-1:0] lanes,
  output utf8d_pkg::out_item_t                                  result
);
  import utf8d_pkg::*;

  logic [2:0]  len;
  logic        ok;
  logic [20:0] cp;

  assign len = lanes[0].lead_len;

  always_comb begin
    ok = (len != LEN_BAD) && !lanes[0].lead_bad
         && ((len < LEN_2) || lanes[1].is_cont)
         && ((len < LEN_3) || lanes[2].is_cont)
         && ((len < LEN_4) || lanes[3].is_cont);
  end

  always_comb begin
    case (len)
      LEN_1:   cp = {14'd0, lanes[0].data};
      LEN_2:   cp = {10'd0, lanes[0].data[4:0], lanes[1].data[5:0]};
      LEN_3:   cp = {5'd0, lanes[0].data[3:0], lanes[1].data[5:0], lanes[2].data[5:0]};
      LEN_4:   cp = {lanes[0].data[2:0], lanes[1].data[5:0], lanes[2].data[5:0],
                     lanes[3].data[5:0]};
      default: cp = 21'd0;
    endcase
  end

  always_comb begin
    if (ok && (cp <= MAX_SCALAR)) begin
      result.code_point = cp;
      result.replaced   = 1'b0;
    end else begin
      result.code_point = REPL_CHAR;
      result.replaced   = 1'b1;
    end
    if (lanes[0].is_nul) begin
      result.advance = ADV_NUL;
    end else if (ok) begin
      result.advance = len;
    end else begin
      result.advance = ADV_INVALID;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/utf8_char_decoder_top.sv
// top level of the utf8 character decoder
// Usage:
// in_valid/in_data/in_stall carries a four-byte window that starts on a
// character boundary; out_valid/out_data/out_stall returns one decoded
// character per window: code point (U+FFFD on bad input), bytes to advance
// and a replacement flag.
// Four lanes classify the window bytes in parallel and their findings are
// registered; a merging stage then forms the result into the output register.
// An accepted window is registered in the lane stage and then in the output register.
// Throughput is one window per cycle while the receiver does not stall; the two-stage register pipeline sets it.
// When the receiver stalls, the output holds and the lane stage can still
// take one more window; in_stall rises only when both stages are full.
// Reset empties both stages; no output is valid after reset.
`default_nettype none

module utf8_char_decoder_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire utf8d_pkg::in_item_t  in_data,
  output logic                      in_stall,
  output logic                      out_valid,
  output utf8d_pkg::out_item_t      out_data,
  input  wire logic                 out_stall
);
  import utf8d_pkg::*;

  lane_info_t [NUM_LANES-1:0] lane_info;
  lane_info_t [NUM_LANES-1:0] s1_lane_r;
  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  out_item_t                  out_data_r;
  out_item_t                  merged;
  logic [7:0]                 win_bytes [NUM_LANES];
  logic                       out_hold;
  logic                       in_fire;
  logic                       s1_fire;

  assign win_bytes[0] = in_data.byte0;
  assign win_bytes[1] = in_data.byte1;
  assign win_bytes[2] = in_data.byte2;
  assign win_bytes[3] = in_data.byte3;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    utf8d_lane u_lane (
      .byte_in (win_bytes[g]),
      .info    (lane_info[g])
    );
  end

  utf8d_merge u_merge (
    .lanes  (s1_lane_r),
    .result (merged)
  );

  assign out_hold = out_valid_r && out_stall;
  assign s1_fire  = s1_valid_r && !out_hold;
  assign in_stall = s1_valid_r && out_hold;
  assign in_fire  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || out_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload stages carry no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_lane_r <= lane_info;
    end
    if (s1_fire) begin
      out_data_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "utf8_char_decoder_top_defines.svh"

  `UTF8D_ASSERT_SAME(a_repl_value, out_valid_r && out_data_r.replaced, out_data_r.code_point == REPL_CHAR, "replacement flag without U+FFFD")
  `UTF8D_ASSERT_SAME(a_nul_result, out_valid_r && (out_data_r.advance == ADV_NUL), (out_data_r.code_point == 21'd0) && !out_data_r.replaced, "nul lead gave non-zero result")
  `UTF8D_ASSERT_SAME(a_adv_range, out_valid_r, out_data_r.advance <= LEN_4, "advance beyond four bytes")
  `UTF8D_ASSERT_NEXT(a_s1_fill, in_fire, s1_valid_r, "accepted transaction lost at lane stage")

endmodule

`default_nettype wire

>>> bench/utf8_decode_checker.sv
`timescale 1ns / 1ps
// checker for the utf8 character decoder: predicts each window's character and compares results

module utf8_decode_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  utf8d_pkg::in_item_t  in_data,
  input  logic                 in_stall,
  input  logic                 out_valid,
  input  utf8d_pkg::out_item_t out_data,
  input  logic                 out_stall,
  output int                   error_count,
  output int                   pending_count
);
  import utf8d_pkg::*;

  out_item_t expected_chars [$];
  int        mismatches = 0;
  int        outstanding = 0;

  assign error_count   = mismatches;
  assign pending_count = outstanding;

  // sequence length from the lead byte, LEN_BAD for a stray continuation or 0xF8 and up
  function automatic logic [2:0] lead_length(logic [7:0] lead);
    if (lead[7:6] == 2'b10) return LEN_BAD;
    if (!lead[7]) return LEN_1;
    if (lead[7:5] == 3'b110) return LEN_2;
    if (lead[7:4] == 4'b1110) return LEN_3;
    if (lead[7:3] == 5'b11110) return LEN_4;
    return LEN_BAD;
  endfunction

  function automatic out_item_t decode_window(in_item_t w);
    logic [7:0]  b [4];
    logic [2:0]  len;
    logic        ok;
    logic [31:0] cp;
    out_item_t   r;
    b[0] = w.byte0;
    b[1] = w.byte1;
    b[2] = w.byte2;
    b[3] = w.byte3;
    len = lead_length(b[0]);
    ok = (len != LEN_BAD);
    for (int k = 1; k < 4; k++)
      if (k < len && b[k][7:6] != 2'b10) ok = 1'b0;
    if (b[0] == 8'hC0 || b[0] == 8'hC1 || b[0] >= 8'hF5) ok = 1'b0;
    r.replaced = 1'b0;
    if (ok) begin
      case (len)
        LEN_1:   cp = {25'd0, b[0][6:0]};
        LEN_2:   cp = {27'd0, b[0][4:0]};
        LEN_3:   cp = {28'd0, b[0][3:0]};
        default: cp = {29'd0, b[0][2:0]};
      endcase
      for (int k = 1; k < 4; k++)
        if (k < len) cp = (cp << 6) | {26'd0, b[k][5:0]};
      if (cp > {11'd0, MAX_SCALAR}) begin
        cp = {11'd0, REPL_CHAR};
        r.replaced = 1'b1;
      end
      r.advance = len;
    end else begin
      cp = {11'd0, REPL_CHAR};
      r.replaced = 1'b1;
      r.advance = ADV_INVALID;
    end
    if (b[0] == 8'h00) r.advance = ADV_NUL;
    r.code_point = cp[20:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("character result with none outstanding: code_point %h advance %0d",
                 out_data.code_point, out_data.advance);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_chars.pop_front();
          if (want != out_data) begin
            if (want.code_point != out_data.code_point)
              $error("code_point: expected %h, got %h", want.code_point, out_data.code_point);
            if (want.advance != out_data.advance)
              $error("advance: expected %0d, got %0d", want.advance, out_data.advance);
            if (want.replaced != out_data.replaced)
              $error("replaced: expected %0b, got %0b", want.replaced, out_data.replaced);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_chars.push_back(decode_window(in_data));
      outstanding <= expected_chars.size();
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// top of the utf8 character decoder bench: clock, reset, window stimulus and verdict

module testbench;
  import utf8d_pkg::*;

  localparam int RANDOM_WINDOWS = 650;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 100000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  in_item_t  in_data;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall;

  int        fail_count;
  int        chars_pending;
  int        cycles = 0;
  logic      calm = 1'b0;

  // corner windows: nul, ascii, stray and rejected leads, extremes of each length,
  // overlong forms, surrogate, encoded replacement char, above-range, bad tails
  localparam logic [31:0] DIRECTED [25] = '{
    32'h00FFFFFF, 32'h00000000, 32'h7F000000, 32'h41FFFFFF, 32'h80808080,
    32'hBFBFBFBF, 32'hC0800000, 32'hC1BF0000, 32'hC280FFFF, 32'hDFBF0000,
    32'hC2C00000, 32'hE0808000, 32'hEDA08000, 32'hEFBFBD00, 32'hEFBFBFFF,
    32'hE228A100, 32'hF0808080, 32'hF48FBFBF, 32'hF4908080, 32'hF5808080,
    32'hF7BFBFBF, 32'hF8808080, 32'hFFFFFFFF, 32'hF090807F, 32'hE1800080
  };

  utf8_char_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  utf8_decode_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall),
    .error_count   (fail_count),
    .pending_count (chars_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: a random hold-off before each transaction, none while calm
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_window(input in_item_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every predicted character has come back
  task automatic wait_for_chars();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] tail_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // mostly well-formed sequences with random payload, some broken, some raw noise
  function automatic in_item_t random_window();
    in_item_t w;
    int kind;
    w = in_item_t'($urandom);
    kind = $urandom_range(0, 9);
    if (kind >= 2) begin
      case (kind)
        2:       w.byte0 = 8'($urandom_range(8'h00, 8'h7F));
        3, 4:    w.byte0 = 8'($urandom_range(8'hC0, 8'hDF));
        5, 6:    w.byte0 = 8'($urandom_range(8'hE0, 8'hEF));
        7, 8:    w.byte0 = 8'($urandom_range(8'hF0, 8'hF7));
        default: w.byte0 = 8'hF4;
      endcase
      w.byte1 = tail_byte();
      w.byte2 = tail_byte();
      w.byte3 = tail_byte();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(1, 3))
          1:       w.byte1 = 8'($urandom);
          2:       w.byte2 = 8'($urandom);
          default: w.byte3 = 8'($urandom);
        endcase
      end
    end
    return w;
  endfunction

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_window(in_item_t'(DIRECTED[i]));
    wait_for_chars();

    for (int i = 0; i < RANDOM_WINDOWS; i++) begin
      calm = ((i / 80) % 3 == 1);
      if (i == RANDOM_WINDOWS / 2) wait_for_chars();
      send_window(random_window());
    end
    wait_for_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && chars_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_lane.sv
hw/rtl/utf8d_merge.sv
hw/rtl/utf8_char_decoder_top.sv
bench/utf8_decode_checker.sv
bench/testbench.sv
